// ===== rtl/lrtc_pkg.sv =====
// Shared types, widths and register codes for the line raster tile clipper.
package lrtc_pkg;

  // Endpoint coordinate width, fixed by the command format
  localparam int unsigned COORD_BITS = 12;
  // Major coordinate, one step past either end of the coordinate range
  localparam int unsigned MAJ_W      = COORD_BITS + 1;
  // Minor coordinate and clipping compares
  localparam int unsigned MIN_W      = COORD_BITS + 2;
  // Doubled deltas
  localparam int unsigned DELTA_W    = COORD_BITS + 2;
  // Error term, peaks below 2x the doubled major delta
  localparam int unsigned ERR_W      = COORD_BITS + 3;

  localparam int unsigned DIM_W      = 7;
  localparam int unsigned PIX_W      = 6;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned COLOR_W    = 32;

  localparam int unsigned DEFAULT_MAX_DIM = 64;
  localparam logic [DIM_W-1:0] FRAME_RESET = 7'd64;

  // Command queue between classifier and walker
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Input line command
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_W-1:0]           line_color;
  } line_cmd_t;

  // Output pixel write
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  // Classified command: endpoints ordered along the major axis
  typedef struct packed {
    logic                         steep;
    logic signed [COORD_BITS-1:0] a1;
    logic signed [COORD_BITS-1:0] b1;
    logic signed [COORD_BITS-1:0] a2;
    logic signed [COORD_BITS-1:0] b2;
    logic signed [DELTA_W-1:0]    da;
    logic signed [DELTA_W-1:0]    db;
    logic                         inc_pos;
    logic [COLOR_W-1:0]           color;
    logic [DIM_W-1:0]             clip_major;
    logic [DIM_W-1:0]             clip_minor;
    logic [DIM_W-1:0]             clip_w;
  } walk_cmd_t;

endpackage

// ===== rtl/lrtc_front.sv =====
// Command classifier: picks the major axis, orders endpoints, builds deltas.
module lrtc_front #(
  parameter int unsigned MAX_DIM = lrtc_pkg::DEFAULT_MAX_DIM
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lrtc_pkg::line_cmd_t         cmd_i,
  input  logic [lrtc_pkg::DIM_W-1:0]  frame_width_i,
  input  logic [lrtc_pkg::DIM_W-1:0]  frame_height_i,
  input  logic                        full_i,
  output logic                        push_o,
  output lrtc_pkg::walk_cmd_t         cmd_o
);
  import lrtc_pkg::*;

  localparam logic [DIM_W-1:0] DimMax = DIM_W'(MAX_DIM);

  logic signed [MAJ_W-1:0] dx, dy, adx, ady, dmaj, dmin;
  logic                    steep, fwd;
  logic [DIM_W-1:0]        cw, ch;

  // Queue space decides acceptance
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    dx    = MAJ_W'(cmd_i.end_x) - MAJ_W'(cmd_i.start_x);
    dy    = MAJ_W'(cmd_i.end_y) - MAJ_W'(cmd_i.start_y);
    adx   = dx[MAJ_W-1] ? -dx : dx;
    ady   = dy[MAJ_W-1] ? -dy : dy;
    steep = !(ady < adx);
    fwd   = steep ? (dy > 0) : (dx > 0);

    // Clamp tile size to the supported maximum
    cw = (frame_width_i  > DimMax) ? DimMax : frame_width_i;
    ch = (frame_height_i > DimMax) ? DimMax : frame_height_i;

    // Order endpoints so the major coordinate ascends
    if (steep) begin
      cmd_o.a1   = fwd ? cmd_i.start_y : cmd_i.end_y;
      cmd_o.b1   = fwd ? cmd_i.start_x : cmd_i.end_x;
      cmd_o.a2   = fwd ? cmd_i.end_y   : cmd_i.start_y;
      cmd_o.b2   = fwd ? cmd_i.end_x   : cmd_i.start_x;
      dmaj       = fwd ? dy : -dy;
      dmin       = fwd ? dx : -dx;
      cmd_o.clip_major = ch;
      cmd_o.clip_minor = cw;
    end else begin
      cmd_o.a1   = fwd ? cmd_i.start_x : cmd_i.end_x;
      cmd_o.b1   = fwd ? cmd_i.start_y : cmd_i.end_y;
      cmd_o.a2   = fwd ? cmd_i.end_x   : cmd_i.start_x;
      cmd_o.b2   = fwd ? cmd_i.end_y   : cmd_i.start_y;
      dmaj       = fwd ? dx : -dx;
      dmin       = fwd ? dy : -dy;
      cmd_o.clip_major = cw;
      cmd_o.clip_minor = ch;
    end

    cmd_o.steep   = steep;
    cmd_o.da      = $signed({dmaj, 1'b0});
    cmd_o.db      = $signed({dmin, 1'b0});
    cmd_o.inc_pos = (dmaj > 0) && (dmin > 0);
    cmd_o.color   = cmd_i.line_color;
    cmd_o.clip_w  = cw;
  end

endmodule

// ===== rtl/lrtc_fifo.sv =====
// Short command queue between the classifier and the walker.
module lrtc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lrtc_pkg::walk_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output lrtc_pkg::walk_cmd_t data_o,
  output logic                empty_o
);
  import lrtc_pkg::*;

  localparam int unsigned PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(CMD_FIFO_DEPTH - 1);

  walk_cmd_t       mem_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lrtc_back.sv =====
// Line walker: steps the error term, clips runs and emits pixel writes.
module lrtc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lrtc_pkg::walk_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lrtc_pkg::pixel_t    out_data_o
);
  import lrtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAW,
    S_FINAL,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  walk_cmd_t               cmd_q, cmd_d;
  logic signed [MAJ_W-1:0] a_q, a_d, run_start_q, run_start_d;
  logic signed [MIN_W-1:0] minor_q, minor_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic                    fin_q, fin_d, tail_q, tail_d;
  logic [PIX_W-1:0]        draw_k_q, draw_k_d, draw_hi_q, draw_hi_d, draw_m_q, draw_m_d;
  logic [PIX_W-1:0]        pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [ADDR_W-1:0]       pend_addr_q, pend_addr_d;
  logic                    pend_valid_q, pend_valid_d;
  pixel_t                  out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    out_free;
  logic signed [ERR_W-1:0] err_add, err_mag, err_step, err_half;
  logic                    step, last_step;
  logic signed [MIN_W-1:0] run_rs, run_re, run_m, run_lo, run_hi, cmaj, cmin;
  logic                    run_vis;
  logic [PIX_W-1:0]        px, py;
  logic [PIX_W+DIM_W-1:0]  row_base;
  logic [ADDR_W-1:0]       addr;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One error-term step at the current major coordinate
  always_comb begin
    err_add   = err_q + ERR_W'(cmd_q.db);
    err_mag   = err_add[ERR_W-1] ? -err_add : err_add;
    step      = err_mag > ERR_W'(cmd_q.da);
    err_step  = cmd_q.inc_pos ? err_add - ERR_W'(cmd_q.da) : err_add + ERR_W'(cmd_q.da);
    last_step = (a_q == MAJ_W'(cmd_q.a2));
    err_half  = ERR_W'(cmd_i.da) >>> 1;
  end

  // Run clipping: closed run in walk, final run on the end point's minor
  always_comb begin
    run_rs = MIN_W'(run_start_q);
    if (state_q == S_FINAL) begin
      run_re = MIN_W'(cmd_q.a2);
      run_m  = MIN_W'(cmd_q.b2);
    end else begin
      run_re = MIN_W'(a_q - MAJ_W'(1));
      run_m  = minor_q;
    end
    cmaj    = MIN_W'($signed({1'b0, cmd_q.clip_major}));
    cmin    = MIN_W'($signed({1'b0, cmd_q.clip_minor}));
    run_lo  = run_rs[MIN_W-1] ? '0 : run_rs;
    run_hi  = (run_re >= cmaj) ? cmaj - MIN_W'(1) : run_re;
    run_vis = !run_m[MIN_W-1] && (run_m < cmin) && (run_lo <= run_hi);
  end

  // Pixel coordinates and linear address for the current draw position
  always_comb begin
    px       = cmd_q.steep ? draw_m_q : draw_k_q;
    py       = cmd_q.steep ? draw_k_q : draw_m_q;
    row_base = (PIX_W+DIM_W)'(py) * (PIX_W+DIM_W)'(cmd_q.clip_w);
    addr     = ADDR_W'(row_base) + ADDR_W'(px);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    a_d          = a_q;
    run_start_d  = run_start_q;
    minor_d      = minor_q;
    err_d        = err_q;
    fin_d        = fin_q;
    tail_d       = tail_q;
    draw_k_d     = draw_k_q;
    draw_hi_d    = draw_hi_q;
    draw_m_d     = draw_m_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_addr_d  = pend_addr_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    cmd_pop_o    = 1'b0;

    // Output register empties once taken
    if (out_free) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          cmd_d       = cmd_i;
          a_d         = MAJ_W'(cmd_i.a1);
          run_start_d = MAJ_W'(cmd_i.a1);
          minor_d     = MIN_W'(cmd_i.b1);
          err_d       = cmd_i.inc_pos ? err_half : -err_half;
          fin_d       = 1'b0;
          tail_d      = 1'b0;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        err_d = step ? err_step : err_add;
        fin_d = last_step;
        if (step) begin
          run_start_d = a_q;
          minor_d     = cmd_q.inc_pos ? minor_q + MIN_W'(1) : minor_q - MIN_W'(1);
        end
        if (!last_step) begin
          a_d = a_q + MAJ_W'(1);
        end
        if (step && run_vis) begin
          draw_k_d  = run_lo[PIX_W-1:0];
          draw_hi_d = run_hi[PIX_W-1:0];
          draw_m_d  = run_m[PIX_W-1:0];
          state_d   = S_DRAW;
        end else if (last_step) begin
          state_d = S_FINAL;
        end
      end
      S_DRAW: begin
        // Previous pixel moves on only when the output register has room
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_d.pixel_x       = pend_x_q;
            out_d.pixel_y       = pend_y_q;
            out_d.pixel_address = pend_addr_q;
            out_d.pixel_color   = cmd_q.color;
            out_d.last_pixel    = 1'b0;
            out_valid_d         = 1'b1;
          end
          pend_x_d     = px;
          pend_y_d     = py;
          pend_addr_d  = addr;
          pend_valid_d = 1'b1;
          if (draw_k_q == draw_hi_q) begin
            if (tail_q) begin
              state_d = S_DONE;
            end else if (fin_q) begin
              state_d = S_FINAL;
            end else begin
              state_d = S_WALK;
            end
          end else begin
            draw_k_d = draw_k_q + PIX_W'(1);
          end
        end
      end
      S_FINAL: begin
        if (run_vis) begin
          draw_k_d  = run_lo[PIX_W-1:0];
          draw_hi_d = run_hi[PIX_W-1:0];
          draw_m_d  = run_m[PIX_W-1:0];
          tail_d    = 1'b1;
          state_d   = S_DRAW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Held-back pixel is the line's last one
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d.pixel_x       = pend_x_q;
          out_d.pixel_y       = pend_y_q;
          out_d.pixel_address = pend_addr_q;
          out_d.pixel_color   = cmd_q.color;
          out_d.last_pixel    = 1'b1;
          out_valid_d         = 1'b1;
          pend_valid_d        = 1'b0;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      a_q          <= '0;
      run_start_q  <= '0;
      minor_q      <= '0;
      err_q        <= '0;
      fin_q        <= 1'b0;
      tail_q       <= 1'b0;
      draw_k_q     <= '0;
      draw_hi_q    <= '0;
      draw_m_q     <= '0;
      pend_x_q     <= '0;
      pend_y_q     <= '0;
      pend_addr_q  <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      a_q          <= a_d;
      run_start_q  <= run_start_d;
      minor_q      <= minor_d;
      err_q        <= err_d;
      fin_q        <= fin_d;
      tail_q       <= tail_d;
      draw_k_q     <= draw_k_d;
      draw_hi_q    <= draw_hi_d;
      draw_m_q     <= draw_m_d;
      pend_x_q     <= pend_x_d;
      pend_y_q     <= pend_y_d;
      pend_addr_q  <= pend_addr_d;
      pend_valid_q <= pend_valid_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // No pixel may be held back between lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("held pixel left over after line end");

  // Draw position never passes the clipped run end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW) |-> (draw_k_q <= draw_hi_q))
    else $error("draw position beyond run end");

  // Flushing the held pixel marks it as the last of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && pend_valid_q && out_free) |=>
      (out_valid_q && out_q.last_pixel && !pend_valid_q))
    else $error("line end flush lost the last flag");

  // The walker only pops a command the queue actually holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (cmd_valid_i && state_q == S_IDLE))
    else $error("command popped from empty queue");

endmodule

// ===== rtl/line_raster_tile_clip.sv =====
// Top level of the line raster tile clipper.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is a
// line command with two signed endpoints and a color. Output channel
// (out_valid_o / out_stall_i / out_data_o): one transaction per pixel write
// that lands inside the tile, in drawing order, last_pixel set on the final
// one. A fully clipped line produces no output transaction.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 is frame_width, index 1
// is frame_height; always ready; write only while the block is idle.
//
// A classifier accepts commands into a two-entry queue; the walker pops one
// at a time. Per line the walker loads the command, walks one major coordinate
// step per cycle (|major delta| + 1 steps), draws one pixel per cycle while
// the output register has room, and closes the line in its final and done
// states; a line's time is set by the one-step-per-cycle walk and pixel drawing.
// A run's pixels come out only once the run closes, each held back until the
// next is known (for the last flag). While out_stall_i holds a pixel in the
// output register, the walker waits at its next pixel; the queue keeps taking
// commands until full. Reset empties the queue and sets both tile sizes to 64.
module line_raster_tile_clip #(
  parameter int unsigned MAX_DIM = lrtc_pkg::DEFAULT_MAX_DIM
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lrtc_pkg::line_cmd_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lrtc_pkg::pixel_t                out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrtc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrtc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lrtc_pkg::*;

  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic             push, full, empty, pop;
  walk_cmd_t        front_cmd, back_cmd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_RESET;
      frame_height_q <= FRAME_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrtc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (in_data_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  lrtc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_cmd),
    .empty_o (empty)
  );

  lrtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the line raster tile clipper: directed table, then random lines.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrtc_pkg::*;

  localparam int TILE_MAX       = DEFAULT_MAX_DIM;
  localparam int MAX_REPORTS    = 10;
  localparam int ITEMS_PER_SEG  = 80;
  localparam int NUM_SEGS       = 6;
  // One line can walk the whole coordinate range without drawing anything;
  // the queue plus the walker can hold that many such lines.
  localparam int LINE_CYCLES_MAX = 4200;
  localparam int SETTLE_CYCLES   = (CMD_FIFO_DEPTH + 1) * LINE_CYCLES_MAX;

  // Indexes outside the register map, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  // How a directed row is checked
  localparam int EXP_PREDICT = -1;
  localparam int EXP_NONE    = 0;
  localparam int EXP_ONE     = 1;

  // Tile size per random segment, extremes and out-of-range values included
  localparam int SEG_TILE_W [NUM_SEGS] = '{64, 1, 23, 127, 48, 1};
  localparam int SEG_TILE_H [NUM_SEGS] = '{64, 1, 41, 100, 7, 64};

  typedef struct {
    logic [DIM_W-1:0] tile_w;
    logic [DIM_W-1:0] tile_h;
    line_cmd_t        cmd;
    int               n_exp;
    pixel_t           pix;
  } line_case_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  line_cmd_t             in_data;
  logic                  out_valid;
  logic                  out_stall;
  pixel_t                out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the tile size registers
  logic [DIM_W-1:0] frame_w;
  logic [DIM_W-1:0] frame_h;

  pixel_t     pending_pixels[$];
  line_case_t dir_cases[$];
  pixel_t     want;
  int         mismatch_count;
  int         send_idle_pct;
  int         recv_idle_pct;

  line_raster_tile_clip #(
    .MAX_DIM(TILE_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Emit the clipped pixels of one run along the major axis at minor coord m
  function automatic void add_run(input bit steep, input int run_lo, input int run_hi,
                                  input int m, input int cw, input int ch,
                                  input logic [COLOR_W-1:0] color);
    int hi;
    int px;
    int py;
    pixel_t p;
    if (run_lo > run_hi) return;
    hi = run_hi;
    if (steep && hi >= ch) hi = ch - 1;
    if (!steep && hi >= cw) hi = cw - 1;
    for (int k = (run_lo < 0) ? 0 : run_lo; k <= hi; k++) begin
      px = steep ? m : k;
      py = steep ? k : m;
      if (px >= 0 && py >= 0 && px < cw && py < ch) begin
        p.pixel_x       = PIX_W'(px);
        p.pixel_y       = PIX_W'(py);
        p.pixel_address = ADDR_W'(py * cw + px);
        p.pixel_color   = color;
        p.last_pixel    = 1'b0;
        pending_pixels.push_back(p);
      end
    end
  endfunction

  // Expected pixel writes of one line command, queued in drawing order
  function automatic void rasterize(input line_cmd_t c);
    int x1, y1, x2, y2, adx, ady;
    int a1, b1, a2, b2;
    int da, db, inc, err, mag, run_start, minor;
    int cw, ch, n_before;
    bit steep;
    x1 = int'($signed(c.start_x));
    y1 = int'($signed(c.start_y));
    x2 = int'($signed(c.end_x));
    y2 = int'($signed(c.end_y));
    adx = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady = (y2 > y1) ? y2 - y1 : y1 - y2;
    cw = (int'(frame_w) > TILE_MAX) ? TILE_MAX : int'(frame_w);
    ch = (int'(frame_h) > TILE_MAX) ? TILE_MAX : int'(frame_h);
    n_before = pending_pixels.size();

    // Shallow lines walk columns, everything else walks rows
    steep = !(ady < adx);
    if (!steep) begin
      if (x1 < x2) begin
        a1 = x1; b1 = y1; a2 = x2; b2 = y2;
      end else begin
        a1 = x2; b1 = y2; a2 = x1; b2 = y1;
      end
    end else begin
      if (y1 < y2) begin
        a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      end else begin
        a1 = y2; b1 = x2; a2 = y1; b2 = x1;
      end
    end

    da = (a2 - a1) * 2;
    db = (b2 - b1) * 2;
    inc = ((da > 0 && db > 0) || (da < 0 && db < 0)) ? 1 : -1;
    err = inc * (a2 - a1);
    run_start = a1;
    minor = b1;
    for (int a = a1; a <= a2; a++) begin
      err += db;
      mag = (err < 0) ? -err : err;
      if (mag > da) begin
        err -= inc * da;
        add_run(steep, run_start, a - 1, minor, cw, ch, c.line_color);
        run_start = a;
        minor += inc;
      end
    end
    // final run sits on the end point's minor coordinate
    add_run(steep, run_start, a2, b2, cw, ch, c.line_color);

    if (pending_pixels.size() > n_before)
      pending_pixels[pending_pixels.size() - 1].last_pixel = 1'b1;
  endfunction

  function automatic line_case_t mk_case(input int w, input int h, input int sx, input int sy,
                                         input int ex, input int ey,
                                         input logic [COLOR_W-1:0] color, input int n_exp,
                                         input int px, input int py, input int addr);
    line_case_t r;
    r.tile_w             = DIM_W'(w);
    r.tile_h             = DIM_W'(h);
    r.cmd.start_x        = COORD_BITS'(sx);
    r.cmd.start_y        = COORD_BITS'(sy);
    r.cmd.end_x          = COORD_BITS'(ex);
    r.cmd.end_y          = COORD_BITS'(ey);
    r.cmd.line_color     = color;
    r.n_exp              = n_exp;
    r.pix.pixel_x        = PIX_W'(px);
    r.pix.pixel_y        = PIX_W'(py);
    r.pix.pixel_address  = ADDR_W'(addr);
    r.pix.pixel_color    = color;
    r.pix.last_pixel     = 1'b1;
    return r;
  endfunction

  // Coordinate a little around a tile dimension
  function automatic logic [COORD_BITS-1:0] near_coord(input logic [DIM_W-1:0] dim);
    int eff;
    eff = (int'(dim) > TILE_MAX) ? TILE_MAX : int'(dim);
    return COORD_BITS'(int'($urandom_range(eff + 16)) - 8);
  endfunction

  function automatic line_cmd_t random_line();
    line_cmd_t c;
    int kind;
    kind = $urandom_range(99);
    c.line_color = $urandom;
    c.start_x    = near_coord(frame_w);
    c.start_y    = near_coord(frame_h);
    c.end_x      = near_coord(frame_w);
    c.end_y      = near_coord(frame_h);
    if (kind < 66) begin
      // lines around the tile as drawn
    end else if (kind < 80) begin
      // axis-aligned lines and points
      case ($urandom_range(2))
        0:       c.end_x = c.start_x;
        1:       c.end_y = c.start_y;
        default: begin
          c.end_x = c.start_x;
          c.end_y = c.start_y;
        end
      endcase
    end else if (kind < 92) begin
      // one endpoint far away, long walk
      if ($urandom_range(1)) begin
        c.start_x = COORD_BITS'($urandom);
        c.start_y = COORD_BITS'($urandom);
      end else begin
        c.end_x = COORD_BITS'($urandom);
        c.end_y = COORD_BITS'($urandom);
      end
    end else begin
      c.start_x = COORD_BITS'($urandom);
      c.start_y = COORD_BITS'($urandom);
      c.end_x   = COORD_BITS'($urandom);
      c.end_y   = COORD_BITS'($urandom);
    end
    return c;
  endfunction

  // Present one command and hold it until the transaction completes
  task automatic send_line(input line_cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH) frame_w = val;
    else if (idx == REG_FRAME_HEIGHT) frame_h = val;
  endtask

  // Wait for every expected pixel, then let clipped lines still in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tile(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted pixel transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected pixel: x=%0d y=%0d addr=%0d color=%h last=%b",
                   out_data.pixel_x, out_data.pixel_y, out_data.pixel_address,
                   out_data.pixel_color, out_data.last_pixel);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
            out_data.pixel_address !== want.pixel_address ||
            out_data.pixel_color !== want.pixel_color ||
            out_data.last_pixel !== want.last_pixel) begin
          if (mismatch_count < MAX_REPORTS)
            $display("pixel mismatch: exp %0d,%0d a=%0d %h %b got %0d,%0d a=%0d %h %b",
                     want.pixel_x, want.pixel_y, want.pixel_address, want.pixel_color,
                     want.last_pixel, out_data.pixel_x, out_data.pixel_y,
                     out_data.pixel_address, out_data.pixel_color, out_data.last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Hang guard
  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    line_cmd_t cmd;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_FRAME_WIDTH;
    cfg_data       = '0;
    frame_w        = FRAME_RESET;
    frame_h        = FRAME_RESET;
    mismatch_count = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 82;

    // Directed rows; the first block runs on the reset tile size
    dir_cases.push_back(mk_case(64, 64, 5, 7, 5, 7, 32'hDEADBEEF, EXP_ONE, 5, 7, 453));
    dir_cases.push_back(mk_case(64, 64, 0, 0, 0, 0, 32'h0000_0000, EXP_ONE, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 63, 63, 63, 63, 32'hFFFF_FFFF, EXP_ONE, 63, 63, 4095));
    dir_cases.push_back(mk_case(64, 64, 64, 0, 64, 0, 32'h1234_5678, EXP_NONE, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, -1, 10, -1, 10, 32'h8765_4321, EXP_NONE, 0, 0, 0));
    // coordinate extremes
    dir_cases.push_back(mk_case(64, 64, -2048, -2048, 2047, 2047, 32'hA5A5_A5A5,
                                EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 2047, -2048, -2048, 2047, 32'h5A5A_5A5A,
                                EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, -2048, 2047, 2047, -2048, 32'hC3C3_C3C3,
                                EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, -2048, 10, 2047, 10, 32'h0F0F_0F0F, EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 20, -2048, 20, 2047, 32'hF0F0_F0F0, EXP_PREDICT, 0, 0, 0));
    // endpoint order reversed, steep and shallow, minor falling along the major
    dir_cases.push_back(mk_case(64, 64, 50, 3, 2, 20, 32'h0000_0001, EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 3, 60, 10, 1, 32'h8000_0000, EXP_PREDICT, 0, 0, 0));
    // minor step on the very first major step leaves an empty run
    dir_cases.push_back(mk_case(64, 64, 0, 0, 10, 9, 32'h1111_2222, EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 0, 0, 3, 2, 32'h3333_4444, EXP_PREDICT, 0, 0, 0));
    // equal deltas take the row walk; then a shallow line with falling y
    dir_cases.push_back(mk_case(64, 64, 10, 10, 0, 0, 32'h5555_6666, EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, 0, 30, 40, 10, 32'h7777_8888, EXP_PREDICT, 0, 0, 0));
    // fully clipped lines
    dir_cases.push_back(mk_case(64, 64, 100, 100, 2000, 1500, 32'h9999_AAAA, EXP_NONE, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 64, -2048, -5, -1, 30, 32'hBBBB_CCCC, EXP_NONE, 0, 0, 0));
    // tile size above the maximum is clamped
    dir_cases.push_back(mk_case(127, 127, 63, 63, 63, 63, 32'hDDDD_EEEE, EXP_ONE, 63, 63, 4095));
    dir_cases.push_back(mk_case(127, 127, 64, 64, 64, 64, 32'h0102_0304, EXP_NONE, 0, 0, 0));
    // zero width or height clips everything
    dir_cases.push_back(mk_case(0, 64, 0, 5, 63, 5, 32'h0506_0708, EXP_NONE, 0, 0, 0));
    dir_cases.push_back(mk_case(64, 0, 0, 0, 63, 63, 32'h090A_0B0C, EXP_NONE, 0, 0, 0));
    // smallest tile and a narrow one
    dir_cases.push_back(mk_case(1, 1, 0, 0, 0, 0, 32'h0D0E_0F10, EXP_ONE, 0, 0, 0));
    dir_cases.push_back(mk_case(1, 1, -5, -5, 5, 5, 32'h1112_1314, EXP_PREDICT, 0, 0, 0));
    dir_cases.push_back(mk_case(10, 64, 9, 63, 9, 63, 32'h1516_1718, EXP_ONE, 9, 63, 639));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (dir_cases[i]) begin
      if (dir_cases[i].tile_w != frame_w || dir_cases[i].tile_h != frame_h)
        set_tile(dir_cases[i].tile_w, dir_cases[i].tile_h);
      send_line(dir_cases[i].cmd);
      if (dir_cases[i].n_exp == EXP_PREDICT) rasterize(dir_cases[i].cmd);
      else if (dir_cases[i].n_exp == EXP_ONE) pending_pixels.push_back(dir_cases[i].pix);
    end

    // Random part: sender mostly busy, then receiver mostly busy, then no idling
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      set_tile(DIM_W'(SEG_TILE_W[seg]), DIM_W'(SEG_TILE_H[seg]));
      case (seg / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_SEG) begin
        cmd = random_line();
        send_line(cmd);
        rasterize(cmd);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lrtc_pkg.sv
rtl/lrtc_front.sv
rtl/lrtc_fifo.sv
rtl/lrtc_back.sv
rtl/line_raster_tile_clip.sv
tb/sv/tb_top.sv
